// File: rtl/hpc_pkg.sv
// Package with the shared types and constants of the half-plane polygon clipper.
`timescale 1ns / 1ps
package hpc_pkg;

  localparam int COORD_W   = 24;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int SIDE_W    = PROD_W + 1;
  localparam int DEN_W     = SIDE_W + 1;
  localparam int MAG_W     = SIDE_W + DIFF_W;
  localparam int NUM_W     = MAG_W + 1;
  localparam int DVS_W     = DEN_W + 1;
  localparam int QSAT_BITS = 40;
  localparam int Q_W       = QSAT_BITS + 2;
  localparam int SUM_W     = Q_W + 1;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int ADDR_W    = 5;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_END_X   = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_Y   = 3'd3;
  localparam logic [IDX_W-1:0] REG_KEEP    = 3'd4;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   final_vertex;
  } vertex_word_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   vertex_present;
    logic   polygon_end;
  } result_word_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   keep_left;
  } line_cfg_t;

  typedef enum logic [1:0] {
    PT_CUR   = 2'd0,
    PT_PREV  = 2'd1,
    PT_FIRST = 2'd2
  } point_sel_t;

  typedef enum logic {
    AXIS_X = 1'b0,
    AXIS_Y = 1'b1
  } axis_t;

  typedef struct packed {
    logic       load_cur;
    point_sel_t side_sel;
    logic       cap_ein;
    logic       cap_cs;
    logic       cap_den;
    logic       seg_close;
    logic       div_start;
    axis_t      axis;
    logic       cap_cross;
    logic       cap_start;
    logic       emit_cross;
    logic       emit_cur;
    logic       commit;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic ein;
    logic cur_in;
    logic prev_in;
    logic first_in;
    logic have_first;
    logic fin;
    logic den_zero;
    logic div_done;
    logic can_emit;
    logic out_free;
  } status_t;

endpackage

// File: rtl/hpc_rdiv.sv
// Serial multiply and rounded restoring divide for one crossing coordinate.
`timescale 1ns / 1ps
module hpc_rdiv
  import hpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [SIDE_W-1:0] num_a,
  input  logic signed [DIFF_W-1:0] num_b,
  input  logic signed [DEN_W-1:0]  den,
  output logic                     done,
  output logic signed [Q_W-1:0]    quot
);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_DONE = 4'b1000
  } ustate_t;

  localparam logic [NUM_W-1:0] QSAT_N = NUM_W'(1) << QSAT_BITS;

  ustate_t           state;
  logic [MAG_W-1:0]  mc;
  logic [DIFF_W-1:0] mp;
  logic [MAG_W-1:0]  acc;
  logic [DEN_W-1:0]  ad;
  logic [NUM_W-1:0]  num;
  logic [DVS_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic              neg;
  logic [CNT_W-1:0]  cnt;

  logic [SIDE_W-1:0] a_abs;
  logic [DIFF_W-1:0] b_abs;
  logic [DEN_W-1:0]  d_abs;
  logic [MAG_W-1:0]  acc_nx;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    rt;
  logic              ge;
  logic [Q_W-1:0]    mag;

  assign a_abs  = num_a[SIDE_W-1] ? SIDE_W'(-num_a) : SIDE_W'(num_a);
  assign b_abs  = num_b[DIFF_W-1] ? DIFF_W'(-num_b) : DIFF_W'(num_b);
  assign d_abs  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign acc_nx = mp[0] ? acc + mc : acc;
  assign dvs    = {ad, 1'b0};
  assign rt     = {rem, num[NUM_W-1]};
  assign ge     = rt >= {1'b0, dvs};
  assign mag    = (quo > QSAT_N) ? Q_W'(QSAT_N) : quo[Q_W-1:0];
  assign quot   = neg ? -$signed(mag) : $signed(mag);
  assign done   = (state == U_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      unique case (state)
        U_IDLE, U_DONE: begin
          if (start) begin
            mc    <= MAG_W'(a_abs);
            mp    <= b_abs;
            acc   <= '0;
            ad    <= d_abs;
            neg   <= num_a[SIDE_W-1] ^ num_b[DIFF_W-1] ^ den[DEN_W-1];
            cnt   <= '0;
            state <= U_MUL;
          end else begin
            state <= U_IDLE;
          end
        end
        U_MUL: begin
          acc <= acc_nx;
          mc  <= mc << 1;
          mp  <= mp >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIFF_W - 1)) begin
            num   <= NUM_W'({acc_nx, 1'b0}) + NUM_W'(ad);
            rem   <= '0;
            quo   <= '0;
            cnt   <= '0;
            state <= U_DIV;
          end
        end
        U_DIV: begin
          rem <= ge ? DVS_W'(rt - {1'b0, dvs}) : DVS_W'(rt);
          quo <= {quo[NUM_W-2:0], ge};
          num <= num << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_W - 1)) begin
            state <= U_DONE;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/hpc_datapath.sv
// Datapath of the clipper: vertex store, side pipeline, crossing unit, held and output words.
`timescale 1ns / 1ps
module hpc_datapath
  import hpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  vertex_word_t vertex,
  input  line_cfg_t    line,
  input  cmd_t         cmd,
  output status_t      status,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result
);

  coord_t cur_x, cur_y, first_x, first_y, prev_x, prev_y;
  coord_t held_x, held_y, cross_x, cross_y;
  logic   cur_fin, cur_in, first_in, prev_in, have_first, held_valid;

  coord_t px, py, sx, sy, ex, ey, s_axis, clamped, src_x, src_y;
  logic signed [DIFF_W-1:0] ldx, ldy, rx, ry, dlt;
  logic signed [PROD_W-1:0] p1, p2;
  logic signed [SIDE_W-1:0] c_reg, cs_reg;
  logic signed [DEN_W-1:0]  den_reg;
  logic signed [Q_W-1:0]    q;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-COORD_W:0]   sum_hi;
  logic                     ein, div_done, out_free, fits;

  always_comb begin
    unique case (cmd.side_sel)
      PT_PREV:  begin px = prev_x;  py = prev_y;  end
      PT_FIRST: begin px = first_x; py = first_y; end
      default:  begin px = cur_x;   py = cur_y;   end
    endcase
  end

  // Side of a point: (L1-L0) x (P-L0), three register stages.
  always_ff @(posedge clk) begin
    ldx   <= DIFF_W'(line.end_x) - DIFF_W'(line.start_x);
    ldy   <= DIFF_W'(line.end_y) - DIFF_W'(line.start_y);
    rx    <= DIFF_W'(px) - DIFF_W'(line.start_x);
    ry    <= DIFF_W'(py) - DIFF_W'(line.start_y);
    p1    <= ldx * ry;
    p2    <= ldy * rx;
    c_reg <= SIDE_W'(p1) - SIDE_W'(p2);
  end

  assign ein = line.keep_left ? (c_reg[SIDE_W-1] || (c_reg == '0)) : !c_reg[SIDE_W-1];

  assign sx = cmd.seg_close ? cur_x : prev_x;
  assign sy = cmd.seg_close ? cur_y : prev_y;
  assign ex = cmd.seg_close ? first_x : cur_x;
  assign ey = cmd.seg_close ? first_y : cur_y;

  assign s_axis = (cmd.axis == AXIS_Y) ? sy : sx;
  assign dlt    = (cmd.axis == AXIS_Y) ? DIFF_W'(ey) - DIFF_W'(sy)
                                       : DIFF_W'(ex) - DIFF_W'(sx);

  hpc_rdiv u_rdiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num_a (cs_reg),
    .num_b (dlt),
    .den   (den_reg),
    .done  (div_done),
    .quot  (q)
  );

  // Saturate the crossing point to the coordinate range.
  assign sum     = SUM_W'(s_axis) + SUM_W'(q);
  assign sum_hi  = sum[SUM_W-1:COORD_W-1];
  assign fits    = (&sum_hi) || !(|sum_hi);
  assign clamped = fits ? sum[COORD_W-1:0]
                 : (sum[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                 : {1'b0, {(COORD_W-1){1'b1}}});

  assign src_x    = cmd.emit_cross ? cross_x : cur_x;
  assign src_y    = cmd.emit_cross ? cross_y : cur_y;
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      held_valid   <= 1'b0;
      have_first   <= 1'b0;
    end else begin
      if (cmd.finish || ((cmd.emit_cross || cmd.emit_cur) && held_valid)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cmd.load_cur) begin
        cur_x   <= vertex.vertex_x;
        cur_y   <= vertex.vertex_y;
        cur_fin <= vertex.final_vertex;
      end
      if (cmd.cap_ein) begin
        cur_in <= ein;
      end
      if (cmd.cap_cs) begin
        cs_reg <= c_reg;
      end
      if (cmd.cap_den) begin
        den_reg <= DEN_W'(cs_reg) - DEN_W'(c_reg);
      end
      if (cmd.cap_start) begin
        cross_x <= sx;
        cross_y <= sy;
      end
      if (cmd.cap_cross) begin
        if (cmd.axis == AXIS_Y) begin
          cross_y <= clamped;
        end else begin
          cross_x <= clamped;
        end
      end
      if (cmd.emit_cross || cmd.emit_cur) begin
        if (held_valid) begin
          result <= '{out_x: held_x, out_y: held_y,
                      vertex_present: 1'b1, polygon_end: 1'b0};
        end
        held_x     <= src_x;
        held_y     <= src_y;
        held_valid <= 1'b1;
      end
      if (cmd.commit) begin
        prev_x  <= cur_x;
        prev_y  <= cur_y;
        prev_in <= cur_in;
        if (!have_first) begin
          first_x  <= cur_x;
          first_y  <= cur_y;
          first_in <= cur_in;
        end
        have_first <= 1'b1;
      end
      if (cmd.finish) begin
        if (held_valid) begin
          result <= '{out_x: held_x, out_y: held_y,
                      vertex_present: 1'b1, polygon_end: 1'b1};
        end else begin
          result <= '{out_x: '0, out_y: '0, vertex_present: 1'b0, polygon_end: 1'b1};
        end
        held_valid <= 1'b0;
        have_first <= 1'b0;
      end
    end
  end

  assign status = '{ein: ein, cur_in: cur_in, prev_in: prev_in, first_in: first_in,
                    have_first: have_first, fin: cur_fin, den_zero: (den_reg == '0),
                    div_done: div_done, can_emit: !held_valid || out_free,
                    out_free: out_free};

endmodule

// File: rtl/hpc_ctrl.sv
// Controller state machine that sequences each vertex through the datapath.
`timescale 1ns / 1ps
module hpc_ctrl
  import hpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    vertex_valid,
  output logic    vertex_ready,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [13:0] {
    S_IDLE       = 14'b00000000000001,
    S_CUR_SIDE   = 14'b00000000000010,
    S_DECIDE     = 14'b00000000000100,
    S_CS_SIDE    = 14'b00000000001000,
    S_CE_SIDE    = 14'b00000000010000,
    S_DEN_CAP    = 14'b00000000100000,
    S_DEN_CHECK  = 14'b00000001000000,
    S_DIV_X      = 14'b00000010000000,
    S_DIV_Y_GO   = 14'b00000100000000,
    S_DIV_Y      = 14'b00001000000000,
    S_EMIT_CROSS = 14'b00010000000000,
    S_EMIT_CUR   = 14'b00100000000000,
    S_COMMIT     = 14'b01000000000000,
    S_FINISH     = 14'b10000000000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] side_cnt;
  logic       seg_close, seg_close_next;
  logic       side_last;

  assign side_last = (side_cnt == 2'd2);

  always_comb begin
    state_next     = state;
    seg_close_next = seg_close;
    cmd            = '0;
    cmd.side_sel   = PT_CUR;
    cmd.axis       = AXIS_X;
    cmd.seg_close  = seg_close;
    vertex_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        vertex_ready = 1'b1;
        if (vertex_valid) begin
          cmd.load_cur = 1'b1;
          state_next   = S_CUR_SIDE;
        end
      end
      S_CUR_SIDE: begin
        if (side_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.cap_ein = 1'b1;
        if (status.have_first && (status.ein != status.prev_in)) begin
          seg_close_next = 1'b0;
          state_next     = S_CS_SIDE;
        end else if (status.ein) begin
          state_next = S_EMIT_CUR;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_CS_SIDE: begin
        cmd.side_sel = seg_close ? PT_CUR : PT_PREV;
        if (side_last) state_next = S_CE_SIDE;
      end
      S_CE_SIDE: begin
        cmd.side_sel = seg_close ? PT_FIRST : PT_CUR;
        cmd.cap_cs   = (side_cnt == 2'd0);
        if (side_last) state_next = S_DEN_CAP;
      end
      S_DEN_CAP: begin
        cmd.cap_den = 1'b1;
        state_next  = S_DEN_CHECK;
      end
      S_DEN_CHECK: begin
        if (status.den_zero) begin
          cmd.cap_start = 1'b1;
          state_next    = S_EMIT_CROSS;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV_X;
        end
      end
      S_DIV_X: begin
        if (status.div_done) begin
          cmd.cap_cross = 1'b1;
          state_next    = S_DIV_Y_GO;
        end
      end
      S_DIV_Y_GO: begin
        cmd.axis      = AXIS_Y;
        cmd.div_start = 1'b1;
        state_next    = S_DIV_Y;
      end
      S_DIV_Y: begin
        cmd.axis = AXIS_Y;
        if (status.div_done) begin
          cmd.cap_cross = 1'b1;
          state_next    = S_EMIT_CROSS;
        end
      end
      S_EMIT_CROSS: begin
        if (status.can_emit) begin
          cmd.emit_cross = 1'b1;
          if (seg_close) state_next = S_FINISH;
          else if (status.cur_in) state_next = S_EMIT_CUR;
          else state_next = S_COMMIT;
        end
      end
      S_EMIT_CUR: begin
        if (status.can_emit) begin
          cmd.emit_cur = 1'b1;
          state_next   = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        if (status.fin && status.have_first && (status.first_in != status.cur_in)) begin
          seg_close_next = 1'b1;
          state_next     = S_CS_SIDE;
        end else if (status.fin) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The x result is captured with the x axis selected; the y divide is started
  // in the next cycle, once the axis select has moved to y.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      side_cnt  <= 2'd0;
      seg_close <= 1'b0;
    end else begin
      state     <= state_next;
      seg_close <= seg_close_next;
      side_cnt  <= (state_next != state) ? 2'd0 : side_cnt + 2'd1;
    end
  end

endmodule

// File: rtl/half_plane_polygon_clip.sv
// Top level of the half-plane polygon clipper: register port, controller and datapath.
`timescale 1ns / 1ps
// Clips a polygon against the half-plane on one side of a configured line.
// Vertices come in on the vertex channel, one word per vertex, with
// final_vertex set on the last vertex of each polygon. Kept vertices and
// edge crossings leave on the result channel in polygon order; polygon_end
// marks the last word of a clipped polygon, and a polygon that is clipped
// away entirely gives a single word with vertex_present low.
// A vertex with no crossing passes through the side-of-line pipeline, then
// decide, emit and commit. Each crossing is worked out by the shared serial
// unit, which multiplies and then divides for each coordinate in turn. A
// vertex can cause up to two crossings (its incoming edge and, on the final
// vertex, the closing edge). One vertex is worked on at a time.
// Results go out one word late through a held word, so that polygon_end can
// be placed on the true last word. When the receiver stalls, the output
// register holds its word and the controller waits before the next emit.
// Reset clears the controller and the polygon state and loads the line
// registers with their defaults: the x axis, keeping the side with cross <= 0.
module half_plane_polygon_clip
  import hpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              vertex_valid,
  output logic              vertex_ready,
  input  vertex_word_t      vertex,
  output logic              result_valid,
  input  logic              result_ready,
  output result_word_t      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  line_cfg_t        line;
  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Register file; indexes past the keep flag are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      line.start_x   <= '0;
      line.start_y   <= '0;
      line.end_x     <= COORD_W'(256);
      line.end_y     <= '0;
      line.keep_left <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_X: line.start_x   <= pwdata[COORD_W-1:0];
        REG_START_Y: line.start_y   <= pwdata[COORD_W-1:0];
        REG_END_X:   line.end_x     <= pwdata[COORD_W-1:0];
        REG_END_Y:   line.end_y     <= pwdata[COORD_W-1:0];
        REG_KEEP:    line.keep_left <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_X: prdata = 32'(unsigned'(line.start_x));
      REG_START_Y: prdata = 32'(unsigned'(line.start_y));
      REG_END_X:   prdata = 32'(unsigned'(line.end_x));
      REG_END_Y:   prdata = 32'(unsigned'(line.end_y));
      REG_KEEP:    prdata = 32'(line.keep_left);
      default:     prdata = '0;
    endcase
  end

  hpc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .cmd          (cmd),
    .status       (status)
  );

  hpc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .vertex       (vertex),
    .line         (line),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: rtl/hpc_checker.sv
// Port-level checks of the clipper and the bind that attaches them.
`timescale 1ns / 1ps
module hpc_checker
  import hpc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         result_valid,
  input logic         result_ready,
  input result_word_t result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.vertex_present |-> result.polygon_end)
    else $error("empty terminator without polygon_end");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.vertex_present |-> result.out_x == '0 && result.out_y == '0)
    else $error("empty terminator with nonzero point");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind half_plane_polygon_clip hpc_checker u_hpc_checker (.*);

// File: tb/hpc_clip_checker.sv
// Checker that predicts the clipped polygon words and compares them with the block's output.
`timescale 1ns / 1ps
module hpc_clip_checker
  import hpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         vertex_valid,
  input  logic         vertex_ready,
  input  vertex_word_t vertex,
  input  logic         result_valid,
  input  logic         result_ready,
  input  result_word_t result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending_count
);

  typedef logic signed [127:0] wide_t;

  coord_t lsx, lsy, lex, ley;
  logic   keep_left;
  coord_t fx, fy, px, py, hx, hy;
  logic   f_in, p_in, have_first, held_valid;
  result_word_t clip_q[$];

  assign pending_count = clip_q.size();

  function automatic wide_t side_of(coord_t x, coord_t y);
    wide_t dx, dy;
    dx = wide_t'(lex) - wide_t'(lsx);
    dy = wide_t'(ley) - wide_t'(lsy);
    return dx * (wide_t'(y) - wide_t'(lsy)) - dy * (wide_t'(x) - wide_t'(lsx));
  endfunction

  function automatic logic kept(wide_t c);
    return keep_left ? (c <= 0) : (c >= 0);
  endfunction

  // Rounded quotient with ties away from zero, magnitude saturated at 2^40.
  function automatic wide_t round_div(wide_t n, wide_t d);
    wide_t an, ad, q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    if (q > (wide_t'(1) <<< 40)) q = wide_t'(1) <<< 40;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic coord_t sat(wide_t v);
    if (v > 128'sd8388607) return coord_t'(24'sh7fffff);
    if (v < -128'sd8388608) return coord_t'(24'sh800000);
    return coord_t'(v);
  endfunction

  task automatic cross_point(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                             output coord_t ox, output coord_t oy);
    wide_t cs, den;
    cs = side_of(sx, sy);
    den = cs - side_of(ex, ey);
    if (den == 0) begin
      ox = sx;
      oy = sy;
    end else begin
      ox = sat(wide_t'(sx) + round_div(cs * (wide_t'(ex) - wide_t'(sx)), den));
      oy = sat(wide_t'(sy) + round_div(cs * (wide_t'(ey) - wide_t'(sy)), den));
    end
  endtask

  // Appends one predicted word at the tail of the queue.
  task automatic queue_word(result_word_t w);
    clip_q = {clip_q, w};
  endtask

  task automatic emit_point(coord_t x, coord_t y);
    if (held_valid) queue_word('{hx, hy, 1'b1, 1'b0});
    hx = x;
    hy = y;
    held_valid = 1'b1;
  endtask

  task automatic clip_vertex(vertex_word_t v);
    logic   ein;
    coord_t cx, cy;
    ein = kept(side_of(v.vertex_x, v.vertex_y));
    if (!have_first) begin
      fx = v.vertex_x;
      fy = v.vertex_y;
      f_in = ein;
    end else if (ein != p_in) begin
      cross_point(px, py, v.vertex_x, v.vertex_y, cx, cy);
      emit_point(cx, cy);
    end
    if (ein) emit_point(v.vertex_x, v.vertex_y);
    px = v.vertex_x;
    py = v.vertex_y;
    p_in = ein;
    have_first = 1'b1;
    if (v.final_vertex) begin
      if (f_in != ein) begin
        cross_point(v.vertex_x, v.vertex_y, fx, fy, cx, cy);
        emit_point(cx, cy);
      end
      if (held_valid) queue_word('{hx, hy, 1'b1, 1'b1});
      else queue_word('{'0, '0, 1'b0, 1'b1});
      have_first = 1'b0;
      held_valid = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    result_word_t exp_w;
    if (rst) begin
      lsx = '0; lsy = '0; lex = coord_t'(256); ley = '0; keep_left = 1'b1;
      fx = '0; fy = '0; px = '0; py = '0; hx = '0; hy = '0;
      f_in = 0; p_in = 0; have_first = 0; held_valid = 0;
      clip_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_START_X: lsx = coord_t'(pwdata);
          REG_START_Y: lsy = coord_t'(pwdata);
          REG_END_X:   lex = coord_t'(pwdata);
          REG_END_Y:   ley = coord_t'(pwdata);
          REG_KEEP:    keep_left = pwdata[0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (clip_q.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, result);
          fail_count++;
        end else begin
          exp_w = clip_q.pop_front();
          if (exp_w !== result) begin
            $display("%0t: mismatch, expected x=%h y=%h p=%b e=%b, actual x=%h y=%h p=%b e=%b",
                     $time, exp_w.out_x, exp_w.out_y, exp_w.vertex_present,
                     exp_w.polygon_end, result.out_x, result.out_y,
                     result.vertex_present, result.polygon_end);
            fail_count++;
          end
        end
      end
      if (vertex_valid && vertex_ready) clip_vertex(vertex);
    end
  end

endmodule

// File: tb/tb_half_plane_polygon_clip.sv
// Testbench top for the half-plane polygon clipper: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb_half_plane_polygon_clip;
  import hpc_pkg::*;

  logic clk, rst;
  logic vertex_valid, vertex_ready;
  vertex_word_t vertex;
  logic result_valid, result_ready;
  result_word_t result;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending_count;

  // Set while the result side is told to hold off for a long stretch.
  logic long_hold;

  half_plane_polygon_clip u_top (.*);

  hpc_clip_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A vertex can cost up to two crossings, so the limit is set far beyond the
  // slowest legal run.
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: a random wait before each word, with a long hold-off
  // requested by the stimulus process.
  initial begin
    int wait_cycles;
    result_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        result_ready <= 1'b0;
        repeat (600) @(negedge clk);
        long_hold = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (wait_cycles > 0) begin
        result_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic reg_write(logic [IDX_W-1:0] idx, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Waits until every predicted word has come out and the block has had
  // time to finish any vertex that produces no word.
  task automatic drain();
    vertex_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  task automatic set_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, logic kl);
    drain();
    reg_write(REG_START_X, 32'(sx));
    reg_write(REG_START_Y, 32'(sy));
    reg_write(REG_END_X, 32'(ex));
    reg_write(REG_END_Y, 32'(ey));
    reg_write(REG_KEEP, {31'd0, kl});
  endtask

  // Offers one vertex word after a random gap and holds it until taken.
  // Valid drops only for a gap, so back-to-back words keep it high.
  task automatic send_vertex(coord_t x, coord_t y, logic fin, logic no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
    if (gap > 0) begin
      vertex_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vertex_valid <= 1'b1;
    vertex <= '{x, y, fin};
    @(posedge clk);
    while (!vertex_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly moderate coordinates so crossings stay in range; sometimes the
  // full field.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 8192)) - 4096);
      default: return coord_t'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  initial begin
    int n;
    int next_line;
    bit hold_done, drain_done;
    coord_t big, low;
    big = coord_t'(24'sh7fffff);
    low = coord_t'(24'sh800000);
    rst = 1'b1;
    long_hold = 1'b0;
    vertex_valid = 1'b0; vertex = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed: default line, a square straddling the x axis.
    send_vertex(-512, -512, 0);
    send_vertex(512, -512, 0);
    send_vertex(512, 512, 0);
    send_vertex(-512, 512, 1);
    // Single kept vertex, single dropped vertex (empty polygon).
    send_vertex(100, -100, 1);
    send_vertex(100, 100, 1);
    // Extremes of the fields.
    send_vertex(big, big, 0);
    send_vertex(low, low, 0);
    send_vertex(big, low, 1);
    // Opposite side, diagonal line.
    set_line(-256, -256, 768, 1024, 1'b0);
    send_vertex(0, 0, 0);
    send_vertex(2000, 0, 0);
    send_vertex(0, 2000, 1);
    // Degenerate line keeps every vertex.
    set_line(300, 300, 300, 300, 1'b1);
    send_vertex(-7, 9, 0);
    send_vertex(low, 5, 0);
    send_vertex(1234, big, 1);
    // Line changed mid-polygon, with extreme line points.
    set_line(low, low, big, big, 1'b1);
    send_vertex(1000, -1000, 0);
    send_vertex(-1000, 1000, 0);
    drain();
    reg_write(REG_END_X, 32'(low));
    reg_write(REG_END_Y, 32'(big));
    send_vertex(2000, -3000, 0);
    send_vertex(big, low, 1);

    // Random polygons, mostly well formed with a few vertices each.
    n = 0;
    next_line = 40;
    hold_done = 1'b0;
    drain_done = 1'b0;
    while (n < 150) begin
      int len;
      if (n >= next_line) begin
        set_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
        next_line += 40;
      end
      if (!hold_done && n >= 60) begin
        // Long receiver hold-off while vertices keep coming back to back.
        hold_done = 1'b1;
        long_hold = 1'b1;
        repeat (12) begin
          send_vertex(rand_coord(), rand_coord(), 1'($urandom_range(0, 3) == 0), 1'b1);
          n++;
        end
      end
      if (!drain_done && n >= 100) begin
        drain_done = 1'b1;
        drain();
      end
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
      for (int i = 0; i < len; i++) begin
        send_vertex(rand_coord(), rand_coord(), i == len - 1);
        n++;
      end
    end
    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: half_plane_polygon_clip.f
rtl/hpc_pkg.sv
rtl/hpc_rdiv.sv
rtl/hpc_datapath.sv
rtl/hpc_ctrl.sv
rtl/half_plane_polygon_clip.sv
rtl/hpc_checker.sv
tb/hpc_clip_checker.sv
tb/tb_half_plane_polygon_clip.sv
